// File: src/wsmg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and small tables for the wind sway matrix generator.
// Used by wsmg_alu, wind_sway_matrix_generator and wsmg_checker; no dependencies.
package wsmg_pkg;

	localparam int NUM_MATRICES = 4;

	localparam logic [16:0] WS_RESET = 17'd19661;
	localparam logic [16:0] WS_MAX   = 17'd65536;

	// base angle = S * 35 deg in Q32 rad = S * BASE_NUM / BASE_DEN
	localparam logic [63:0] BASE_NUM = 64'd22937600000000;
	localparam logic [35:0] BASE_DEN = 36'd572957795;

	localparam logic [35:0] TWO_PI_Q32  = 36'h6487ED511;
	localparam logic [35:0] HALF_PI_Q32 = 36'h1921FB544;
	localparam logic [32:0] QTR_PI_Q32  = 33'h0C90FDAA2;
	localparam logic [30:0] Q30_ONE     = 31'h40000000;
	localparam logic [35:0] ARG_DIVISOR = 36'd5;

	// serial unit: one multiplier bit or one quotient bit per cycle
	localparam int OPB_W     = 36;
	localparam int MUL_STEPS = OPB_W;
	localparam int DIV_STEPS = 64;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic              go;
		alu_op_t           op;
		logic [63:0]       opa;
		logic [OPB_W-1:0]  opb;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

	// sway frequencies in hundredths of Hz, x then y
	function automatic logic [4:0] freq_hz100(input logic [1:0] k, input logic sel_y);
		logic [4:0] f;
		unique case (k)
			2'd0:    f = sel_y ? 5'd17 : 5'd15;
			2'd1:    f = sel_y ? 5'd15 : 5'd25;
			2'd2:    f = sel_y ? 5'd5  : 5'd19;
			default: f = sel_y ? 5'd22 : 5'd15;
		endcase
		return f;
	endfunction

	// Horner divisors: sine terms first, then cosine terms
	function automatic logic [5:0] poly_div(input logic [2:0] j);
		logic [5:0] d;
		unique case (j)
			3'd0:    d = 6'd42;
			3'd1:    d = 6'd20;
			3'd2:    d = 6'd6;
			3'd3:    d = 6'd56;
			3'd4:    d = 6'd30;
			3'd5:    d = 6'd12;
			default: d = 6'd2;
		endcase
		return d;
	endfunction

endpackage

// File: src/wsmg_alu.sv
`timescale 1ns / 1ps
// Shared bit-serial multiply / divide unit (shift-add, restoring division).
// Depends on wsmg_pkg.
module wsmg_alu import wsmg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  alu_req_t         req,
	output alu_sts_t         sts,
	output logic [63:0]      res,
	output logic [OPB_W-1:0] rem
);

	logic             busy_q;
	logic             done_q;
	alu_op_t          op_q;
	logic [CNT_W-1:0] cnt_q;

	logic [63:0]      res_q;
	logic [63:0]      mc_q;
	logic [OPB_W-1:0] opb_q;
	logic [OPB_W-1:0] rem_q;

	logic [OPB_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, res_q[63]};
	assign ge    = (trial >= {1'b0, opb_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ALU_MUL;
			cnt_q  <= '0;
		end else if (req.go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			op_q   <= req.op;
			cnt_q  <= (req.op == ALU_MUL) ? CNT_W'(MUL_STEPS) : CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			res_q <= (req.op == ALU_MUL) ? 64'd0 : req.opa;
			mc_q  <= req.opa;
			opb_q <= req.opb;
			rem_q <= '0;
		end else if (busy_q) begin
			unique case (op_q)
				ALU_MUL: begin
					if (opb_q[0])
						res_q <= res_q + mc_q;
					mc_q  <= {mc_q[62:0], 1'b0};
					opb_q <= {1'b0, opb_q[OPB_W-1:1]};
				end
				ALU_DIV: begin
					rem_q <= ge ? OPB_W'(trial - {1'b0, opb_q}) : trial[OPB_W-1:0];
					res_q <= {res_q[62:0], ge};
				end
			endcase
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = res_q;
	assign rem      = rem_q;

endmodule

// File: src/wind_sway_matrix_generator.sv
`timescale 1ns / 1ps
// Wind sway matrix generator: one time stamp in, four sway rotation results out.
// Depends on wsmg_pkg and wsmg_alu.
//
// Each accepted time word (unsigned Q16.16 seconds) advances four phase timers
// by the wrapped time difference, rescales them by old/new strength when the
// wind strength changed and is nonzero, and then produces one result word per
// matrix (index 0..3, last_matrix set on index 3) carrying eight signed Q1.14
// entries of the x-then-y sway rotation. All multiplies and divides run through a
// single shared serial unit that retires one multiplier bit or one quotient bit
// per clock. One sine/cosine evaluation is 9 divides and 9 multiplies; one
// matrix needs four of them plus ten multiplies and two divides, with one more
// multiply and divide when the timers are rescaled. The pace of a tick is set
// by that serial unit, plus any time a finished result waits on out_stall.
// The block takes one time word at a time (in_stall is high from acceptance
// until the last result of the tick has been placed in the output register);
// the output register lets the next matrix be computed while a result waits.
// wind_strength is to be written through cfg_we/cfg_data only while idle; the
// block itself does not enforce this. Values above 65536 are stored as 65536.
// Strength zero gives identity matrices.
module wind_sway_matrix_generator import wsmg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [16:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        time_now,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         matrix_index,
	output logic               last_matrix,
	output logic signed [15:0] cos_y,
	output logic signed [15:0] neg_sin_y,
	output logic signed [15:0] sinx_siny,
	output logic signed [15:0] cos_x,
	output logic signed [15:0] sinx_cosy,
	output logic signed [15:0] siny_cosx,
	output logic signed [15:0] neg_sin_x,
	output logic signed [15:0] cosx_cosy
);

	typedef enum logic [4:0] {
		IDLE,
		BASE_MUL,
		BASE_DIV,
		T_ADD,
		RS_MUL,
		RS_DIV,
		ARG_MUL1,
		ARG_MUL2,
		ARG_DIV,
		ARG_DONE,
		SW_MUL,
		SW_DONE,
		PR_MUL,
		EMIT,
		SC_MOD,
		SC_QUAD,
		SC_X2,
		SC_PMUL,
		SC_PDIV,
		SC_SMUL,
		SC_FIN
	} state_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// Q30 to Q1.14, half away from zero
	function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
		logic [31:0] m;
		logic [31:0] r;
		m = mag32(v);
		r = (m + 32'd32768) >> 16;
		return v[31] ? $signed(16'(-r[15:0])) : $signed(r[15:0]);
	endfunction

	// control state
	state_t      state_q;
	logic        pend_q;
	logic [16:0] ws_q;
	logic [31:0] prev_time_q;
	logic [31:0] timer_q [NUM_MATRICES];
	logic [16:0] prev_str_q;
	logic        first_done_q;
	logic [1:0]  k_q;
	logic [1:0]  ph_q;      // 0 arg x, 1 arg y, 2 sway x, 3 sway y
	logic [2:0]  j_q;       // Horner step
	logic [1:0]  pidx_q;    // cross product index
	logic        out_valid_q;

	// datapath
	logic [16:0]        s_q;
	logic [16:0]        old_str_q;
	logic               rescale_q;
	logic [31:0]        delta_q;
	logic [31:0]        base_q;
	logic [31:0]        t_q;
	logic [1:0]         quad_q;
	logic               swap_q;
	logic [29:0]        x_q;
	logic [29:0]        x2_q;
	logic [30:0]        ts_q;
	logic [30:0]        tc_q;
	logic signed [31:0] sc_s_q;
	logic signed [31:0] sc_c_q;
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	logic signed [31:0] sx_q;
	logic signed [31:0] cx_q;
	logic signed [31:0] sy_q;
	logic signed [31:0] cy_q;
	logic signed [31:0] pr_q [4];

	logic [1:0]         mi_q;
	logic               last_q;
	logic signed [15:0] cos_y_q;
	logic signed [15:0] neg_sin_y_q;
	logic signed [15:0] sinx_siny_q;
	logic signed [15:0] cos_x_q;
	logic signed [15:0] sinx_cosy_q;
	logic signed [15:0] siny_cosx_q;
	logic signed [15:0] neg_sin_x_q;
	logic signed [15:0] cosx_cosy_q;

	alu_req_t         alu_req;
	alu_sts_t         alu_sts;
	logic [63:0]      alu_res;
	logic [OPB_W-1:0] alu_rem;
	logic             alu_done;
	logic             emit_ok;
	logic             in_take;
	logic             is_last_k;

	logic               op_is;
	alu_op_t            op_sel;
	logic [63:0]        opa_sel;
	logic [OPB_W-1:0]   opb_sel;
	logic signed [31:0] pa;
	logic signed [31:0] pb;
	logic [32:0]        sc_r;
	logic [32:0]        sc_rr;
	logic               sc_swap;
	logic [30:0]        sc_sv;
	logic [30:0]        sc_cv;
	logic [30:0]        poly_cur;
	logic [16:0]        old_eff;

	assign alu_done  = alu_sts.done;
	assign in_stall  = (state_q != IDLE);
	assign in_take   = in_valid && (state_q == IDLE);
	assign emit_ok   = !out_valid_q || !out_stall;
	assign is_last_k = (k_q == 2'(NUM_MATRICES - 1));
	assign old_eff   = first_done_q ? prev_str_q : ws_q;
	assign poly_cur  = (j_q < 3'd3) ? ts_q : tc_q;

	// cross product operands
	always_comb begin
		unique case (pidx_q)
			2'd0:    begin pa = sx_q; pb = sy_q; end
			2'd1:    begin pa = sx_q; pb = cy_q; end
			2'd2:    begin pa = sy_q; pb = cx_q; end
			default: begin pa = cx_q; pb = cy_q; end
		endcase
	end

	// octant fold of the quadrant remainder
	assign sc_r    = alu_rem[32:0];
	assign sc_swap = (sc_r > QTR_PI_Q32);
	assign sc_rr   = sc_swap ? (HALF_PI_Q32[32:0] - sc_r) : sc_r;
	assign sc_sv   = swap_q ? tc_q : ts_q;
	assign sc_cv   = swap_q ? ts_q : tc_q;

	// operation issued to the serial unit in each state
	always_comb begin
		op_is   = 1'b1;
		op_sel  = ALU_MUL;
		opa_sel = '0;
		opb_sel = '0;
		unique case (state_q)
			BASE_MUL: begin opa_sel = BASE_NUM; opb_sel = OPB_W'(s_q); end
			BASE_DIV: begin op_sel = ALU_DIV; opa_sel = alu_res; opb_sel = BASE_DEN; end
			RS_MUL:   begin opa_sel = 64'(t_q); opb_sel = OPB_W'(old_str_q); end
			RS_DIV:   begin op_sel = ALU_DIV; opa_sel = alu_res; opb_sel = OPB_W'(s_q); end
			ARG_MUL1: begin opa_sel = 64'(t_q); opb_sel = OPB_W'(s_q); end
			ARG_MUL2: begin
				opa_sel = alu_res;
				opb_sel = OPB_W'(freq_hz100(k_q, ph_q[0]));
			end
			ARG_DIV:  begin op_sel = ALU_DIV; opa_sel = alu_res; opb_sel = ARG_DIVISOR; end
			SW_MUL:   begin
				opa_sel = 64'(base_q);
				opb_sel = OPB_W'(ph_q[0] ? mag32(py_q) : mag32(px_q));
			end
			PR_MUL:   begin opa_sel = 64'(mag32(pa)); opb_sel = OPB_W'(mag32(pb)); end
			SC_MOD:   begin
				op_sel  = ALU_DIV;
				opa_sel = ph_q[1] ? {30'd0, alu_res[63:30]} : alu_res;
				opb_sel = TWO_PI_Q32;
			end
			SC_QUAD:  begin op_sel = ALU_DIV; opa_sel = 64'(alu_rem); opb_sel = HALF_PI_Q32; end
			SC_X2:    begin opa_sel = 64'(x_q); opb_sel = OPB_W'(x_q); end
			SC_PMUL:  begin opa_sel = 64'(x2_q); opb_sel = OPB_W'(poly_cur); end
			SC_PDIV:  begin
				op_sel  = ALU_DIV;
				opa_sel = {30'd0, alu_res[63:30]};
				opb_sel = OPB_W'(poly_div(j_q));
			end
			SC_SMUL:  begin opa_sel = 64'(x_q); opb_sel = OPB_W'(ts_q); end
			default:  op_is = 1'b0;
		endcase
	end

	assign alu_req.go  = op_is && !pend_q;
	assign alu_req.op  = op_sel;
	assign alu_req.opa = opa_sel;
	assign alu_req.opb = opb_sel;

	wsmg_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.sts    (alu_sts),
		.res    (alu_res),
		.rem    (alu_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			pend_q       <= 1'b0;
			ws_q         <= WS_RESET;
			prev_time_q  <= '0;
			for (int i = 0; i < NUM_MATRICES; i++)
				timer_q[i] <= '0;
			prev_str_q   <= '0;
			first_done_q <= 1'b0;
			k_q          <= '0;
			ph_q         <= '0;
			j_q          <= '0;
			pidx_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				ws_q <= (cfg_data > WS_MAX) ? WS_MAX : cfg_data;
			if (state_q == EMIT && emit_ok)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (alu_req.go)
				pend_q <= 1'b1;
			else if (alu_done)
				pend_q <= 1'b0;

			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						prev_time_q  <= time_now;
						prev_str_q   <= ws_q;
						first_done_q <= 1'b1;
						k_q          <= '0;
						state_q      <= BASE_MUL;
					end
				end
				BASE_MUL: if (alu_done) state_q <= BASE_DIV;
				BASE_DIV: if (alu_done) state_q <= T_ADD;
				T_ADD: begin
					timer_q[k_q] <= timer_q[k_q] + delta_q;
					ph_q         <= '0;
					state_q      <= rescale_q ? RS_MUL : ARG_MUL1;
				end
				RS_MUL: if (alu_done) state_q <= RS_DIV;
				RS_DIV: begin
					if (alu_done) begin
						timer_q[k_q] <= alu_res[31:0];
						state_q      <= ARG_MUL1;
					end
				end
				ARG_MUL1: if (alu_done) state_q <= ARG_MUL2;
				ARG_MUL2: if (alu_done) state_q <= ARG_DIV;
				ARG_DIV:  if (alu_done) state_q <= SC_MOD;
				ARG_DONE: begin
					ph_q    <= ph_q + 1'b1;
					state_q <= ph_q[0] ? SW_MUL : ARG_MUL1;
				end
				SW_MUL: if (alu_done) state_q <= SC_MOD;
				SW_DONE: begin
					if (ph_q[0]) begin
						pidx_q  <= '0;
						state_q <= PR_MUL;
					end else begin
						ph_q    <= ph_q + 1'b1;
						state_q <= SW_MUL;
					end
				end
				PR_MUL: begin
					if (alu_done) begin
						pidx_q <= pidx_q + 1'b1;
						if (pidx_q == 2'd3)
							state_q <= EMIT;
					end
				end
				EMIT: begin
					if (emit_ok) begin
						k_q     <= k_q + 1'b1;
						state_q <= is_last_k ? IDLE : T_ADD;
					end
				end
				SC_MOD:  if (alu_done) state_q <= SC_QUAD;
				SC_QUAD: begin
					if (alu_done) begin
						j_q     <= '0;
						state_q <= SC_X2;
					end
				end
				SC_X2: if (alu_done) state_q <= SC_PMUL;
				SC_PMUL: if (alu_done) state_q <= SC_PDIV;
				SC_PDIV: begin
					if (alu_done) begin
						j_q     <= j_q + 1'b1;
						state_q <= (j_q == 3'd6) ? SC_SMUL : SC_PMUL;
					end
				end
				SC_SMUL: if (alu_done) state_q <= SC_FIN;
				SC_FIN:  state_q <= ph_q[1] ? SW_DONE : ARG_DONE;
				default: state_q <= IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			s_q       <= ws_q;
			old_str_q <= old_eff;
			rescale_q <= (ws_q != old_eff) && (ws_q != 17'd0);
			delta_q   <= time_now - prev_time_q;
		end
		if (state_q == BASE_DIV && alu_done)
			base_q <= alu_res[31:0];
		if (state_q == T_ADD)
			t_q <= timer_q[k_q] + delta_q;
		if (state_q == RS_DIV && alu_done)
			t_q <= alu_res[31:0];
		if (state_q == SC_QUAD && alu_done) begin
			quad_q <= alu_res[1:0];
			swap_q <= sc_swap;
			x_q    <= sc_rr[31:2];
			ts_q   <= Q30_ONE;
			tc_q   <= Q30_ONE;
		end
		if (state_q == SC_X2 && alu_done)
			x2_q <= alu_res[59:30];
		if (state_q == SC_PDIV && alu_done) begin
			if (j_q < 3'd3)
				ts_q <= Q30_ONE - alu_res[30:0];
			else
				tc_q <= Q30_ONE - alu_res[30:0];
		end
		if (state_q == SC_SMUL && alu_done)
			ts_q <= alu_res[60:30];
		if (state_q == SC_FIN) begin
			unique case (quad_q)
				2'd0: begin
					sc_s_q <= $signed({1'b0, sc_sv});
					sc_c_q <= $signed({1'b0, sc_cv});
				end
				2'd1: begin
					sc_s_q <= $signed({1'b0, sc_cv});
					sc_c_q <= -$signed({1'b0, sc_sv});
				end
				2'd2: begin
					sc_s_q <= -$signed({1'b0, sc_sv});
					sc_c_q <= -$signed({1'b0, sc_cv});
				end
				default: begin
					sc_s_q <= -$signed({1'b0, sc_cv});
					sc_c_q <= $signed({1'b0, sc_sv});
				end
			endcase
		end
		if (state_q == ARG_DONE) begin
			if (ph_q[0])
				py_q <= sc_c_q;
			else
				px_q <= sc_s_q;
		end
		if (state_q == SW_DONE) begin
			if (ph_q[0]) begin
				sy_q <= py_q[31] ? -sc_s_q : sc_s_q;
				cy_q <= sc_c_q;
			end else begin
				sx_q <= px_q[31] ? -sc_s_q : sc_s_q;
				cx_q <= sc_c_q;
			end
		end
		// full-scale product (1.0 * 1.0) needs bit 60
		if (state_q == PR_MUL && alu_done)
			pr_q[pidx_q] <= (pa[31] ^ pb[31]) ? -$signed({1'b0, alu_res[60:30]})
			                                  : $signed({1'b0, alu_res[60:30]});
		if (state_q == EMIT && emit_ok) begin
			mi_q        <= k_q;
			last_q      <= is_last_k;
			cos_y_q     <= to_q14(cy_q);
			neg_sin_y_q <= to_q14(-sy_q);
			sinx_siny_q <= to_q14(pr_q[0]);
			cos_x_q     <= to_q14(cx_q);
			sinx_cosy_q <= to_q14(pr_q[1]);
			siny_cosx_q <= to_q14(pr_q[2]);
			neg_sin_x_q <= to_q14(-sx_q);
			cosx_cosy_q <= to_q14(pr_q[3]);
		end
	end

	assign out_valid    = out_valid_q;
	assign matrix_index = mi_q;
	assign last_matrix  = last_q;
	assign cos_y        = cos_y_q;
	assign neg_sin_y    = neg_sin_y_q;
	assign sinx_siny    = sinx_siny_q;
	assign cos_x        = cos_x_q;
	assign sinx_cosy    = sinx_cosy_q;
	assign siny_cosx    = siny_cosx_q;
	assign neg_sin_x    = neg_sin_x_q;
	assign cosx_cosy    = cosx_cosy_q;

endmodule

// File: src/wsmg_checker.sv
`timescale 1ns / 1ps
// Port-level checks for wind_sway_matrix_generator, bound to the top level.
// Depends on wsmg_pkg.
module wsmg_checker import wsmg_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         matrix_index,
	input logic               last_matrix,
	input logic signed [15:0] cos_x,
	input logic signed [15:0] cos_y
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(matrix_index) && $stable(cos_x))
		else $error("stalled result word changed");

	// one time word at a time
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a tick is in progress");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_matrix == (matrix_index == 2'(NUM_MATRICES - 1))))
		else $error("last_matrix does not match matrix_index");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cos_x >= -16'sd16384) && (cos_x <= 16'sd16384) &&
		              (cos_y >= -16'sd16384) && (cos_y <= 16'sd16384))
		else $error("cosine entry outside Q1.14 unit range");

endmodule

bind wind_sway_matrix_generator wsmg_checker u_wsmg_checker (.*);
